// ===== src/telegram_length_and_checksum_check_assert.svh =====
// ----------------------------------------------------------------------------
// Telegram check assertion macros
// Shared property wrappers for the telegram length and checksum check block.
// ----------------------------------------------------------------------------
`ifndef TELEGRAM_LENGTH_AND_CHECKSUM_CHECK_ASSERT_SVH
`define TELEGRAM_LENGTH_AND_CHECKSUM_CHECK_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLCC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("telegram check: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define TLCC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("telegram check: next-cycle property failed");

`endif

// ===== src/tlcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Telegram check package
// Types, status codes and the per-byte helper functions of the block.
// ----------------------------------------------------------------------------
package tlcc_pkg;

    localparam int W_BYTE = 8;
    localparam int W_LEN  = 5;
    localparam int W_SUM  = 9;

    localparam logic [W_LEN-1:0] MIN_LENGTH_RESET = 5'd6;
    localparam logic [W_LEN-1:0] COUNT_MAX        = 5'd31;
    localparam logic [W_LEN-1:0] IDX_LENGTH_BYTE  = 5'd1;
    localparam logic [W_LEN-1:0] IDX_SUM_BYTE     = 5'd2;

    localparam logic [W_LEN-1:0] LEN_CODE0 = 5'd6;
    localparam logic [W_LEN-1:0] LEN_CODE1 = 5'd8;
    localparam logic [W_LEN-1:0] LEN_CODE2 = 5'd12;
    localparam logic [W_LEN-1:0] LEN_CODE3 = 5'd20;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_MORE    = 2'd1,
        ST_BAD_SUM = 2'd2
    } t_status;

    typedef struct packed {
        logic              last;
        logic [W_BYTE-1:0] data;
    } t_item;

    typedef struct packed {
        logic [W_BYTE-1:0] computed_sum;
        logic [W_LEN-1:0]  frame_length;
        t_status           status;
    } t_result;

    // Telegram length selected by bits 3:2 of the header byte.
    function automatic logic [W_LEN-1:0] length_code(input logic [W_BYTE-1:0] b);
        logic [W_LEN-1:0] len;
        case (b[3:2])
            2'd0: begin
                len = LEN_CODE0;
            end
            2'd1: begin
                len = LEN_CODE1;
            end
            2'd2: begin
                len = LEN_CODE2;
            end
            default: begin
                len = LEN_CODE3;
            end
        endcase
        return len;
    endfunction

    // Add the byte, rotate the 9-bit value left by two, fold bit 8 back as +1.
    function automatic logic [W_SUM-1:0] sum_update(input logic [W_SUM-1:0] sum,
                                                    input logic [W_BYTE-1:0] b);
        logic [W_SUM-1:0] v;
        logic [W_SUM-1:0] r;
        v = sum + W_SUM'(b);
        r = {v[W_SUM-3:0], v[W_SUM-1:W_SUM-2]};
        if (r[W_SUM-1]) begin
            r = {1'b0, r[W_SUM-2:0]} + W_SUM'(1);
        end
        return r;
    endfunction

endpackage

// ===== src/telegram_length_and_checksum_check.sv =====
// Timing: an accepted byte beat waits in the input register until the core takes it; the
// edge at which the core takes a buffer's last byte also loads its verdict into the output
// register, and that last byte waits while an earlier verdict there has not been taken.
// Throughput: one byte beat per cycle unless a last byte waits for the output register;
// the per-byte add, rotate, fold is a single stage from input register to checksum state.
// Reset: synchronous, active low; clears all frame state and sets min_length to 6.
// ----------------------------------------------------------------------------
// Telegram length and checksum check
// Checks the length field and 9-bit rotating checksum of received telegrams.
// ----------------------------------------------------------------------------
module telegram_length_and_checksum_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: min_length
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    // Byte stream in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // end_of_buffer
    // Verdict stream out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [1:0] status, [6:2] frame_length,
                                     // [14:7] computed_sum, [15] zero
);

    // Each byte beat first lands in an input register. From there it is taken
    // by the core, which updates the byte count, length and checksum state in
    // one step. Only the last byte of a buffer yields a verdict, so ordinary
    // bytes advance freely; the last byte waits only while the output register
    // is still holding an earlier verdict that has not been taken.

    tlcc_pkg::t_item   in_item;
    tlcc_pkg::t_item   held_item;
    logic              held_valid;
    logic              advance;
    logic              out_free;
    logic              out_load;
    tlcc_pkg::t_result core_result;
    tlcc_pkg::t_result out_result;

    assign in_item.data = i_s_tdata;
    assign in_item.last = i_s_tlast;

    assign advance  = held_valid && (!held_item.last || out_free);
    assign out_load = advance && held_item.last;

    tlcc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    tlcc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (advance),
        .i_item      (held_item),
        .o_result    (core_result)
    );

    tlcc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (out_load),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (out_result)
    );

    // The verdict packs status lowest, then frame length, then the checksum.
    assign o_m_tdata = {1'b0, out_result};

endmodule

// ===== src/tlcc_in_reg.sv =====
// ----------------------------------------------------------------------------
// Telegram check input register
// Holds one received beat until the checksum core has taken it.
// ----------------------------------------------------------------------------
module tlcc_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tlcc_pkg::t_item i_item,
    input  logic            i_advance,
    output logic            o_valid,
    output tlcc_pkg::t_item o_item
);

    logic            r_valid;
    logic            n_valid;
    tlcc_pkg::t_item r_item;
    logic            load;

    assign o_ready = !r_valid || i_advance;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== src/tlcc_core.sv =====
// ----------------------------------------------------------------------------
// Telegram check core
// Per-byte length decode, checksum update and end-of-buffer verdict.
// ----------------------------------------------------------------------------
`include "telegram_length_and_checksum_check_assert.svh"

module tlcc_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tlcc_pkg::W_LEN-1:0]       i_cfg_wdata,
    input  logic                             i_fire,
    input  tlcc_pkg::t_item                  i_item,
    output tlcc_pkg::t_result                o_result
);

    logic [tlcc_pkg::W_LEN-1:0]  r_min_length;
    logic [tlcc_pkg::W_LEN-1:0]  r_byte_count;
    logic [tlcc_pkg::W_LEN-1:0]  r_expected_length;
    logic [tlcc_pkg::W_SUM-1:0]  r_running_sum;
    logic [tlcc_pkg::W_BYTE-1:0] r_received_sum;
    logic                        r_frame_done;

    logic [tlcc_pkg::W_LEN-1:0]  n_byte_count;
    logic [tlcc_pkg::W_LEN-1:0]  n_expected_length;
    logic [tlcc_pkg::W_SUM-1:0]  n_running_sum;
    logic [tlcc_pkg::W_BYTE-1:0] n_received_sum;
    logic                        n_frame_done;
    tlcc_pkg::t_status           status;
    logic                        sum_at_top;
    logic                        sum_low_zero;
    logic                        length_ok;

    always_comb begin
        n_expected_length = r_expected_length;
        n_received_sum    = r_received_sum;
        n_running_sum     = r_running_sum;
        if (!r_frame_done) begin
            if (r_byte_count == tlcc_pkg::IDX_LENGTH_BYTE) begin
                n_expected_length = tlcc_pkg::length_code(i_item.data);
            end
            if (r_byte_count == tlcc_pkg::IDX_SUM_BYTE) begin
                n_received_sum = i_item.data;
            end else begin
                n_running_sum = tlcc_pkg::sum_update(r_running_sum, i_item.data);
            end
        end
        n_byte_count = (r_byte_count != tlcc_pkg::COUNT_MAX) ?
                       r_byte_count + tlcc_pkg::W_LEN'(1) : r_byte_count;
        n_frame_done = r_frame_done ||
                       ((n_expected_length != '0) && (n_byte_count == n_expected_length));
    end

    always_comb begin
        if ((n_byte_count < r_min_length) || !n_frame_done) begin
            status = tlcc_pkg::ST_MORE;
        end else if (n_running_sum[tlcc_pkg::W_BYTE-1:0] != n_received_sum) begin
            status = tlcc_pkg::ST_BAD_SUM;
        end else begin
            status = tlcc_pkg::ST_VALID;
        end
    end

    assign o_result.status       = status;
    assign o_result.frame_length = n_expected_length;
    assign o_result.computed_sum = n_running_sum[tlcc_pkg::W_BYTE-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= tlcc_pkg::MIN_LENGTH_RESET;
        end else if (i_cfg_we) begin
            r_min_length <= i_cfg_wdata;
        end
    end

    // The last byte of a buffer clears the frame state for the next buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count      <= '0;
            r_expected_length <= '0;
            r_running_sum     <= '0;
            r_received_sum    <= '0;
            r_frame_done      <= 1'b0;
        end else if (i_fire) begin
            if (i_item.last) begin
                r_byte_count      <= '0;
                r_expected_length <= '0;
                r_running_sum     <= '0;
                r_received_sum    <= '0;
                r_frame_done      <= 1'b0;
            end else begin
                r_byte_count      <= n_byte_count;
                r_expected_length <= n_expected_length;
                r_running_sum     <= n_running_sum;
                r_received_sum    <= n_received_sum;
                r_frame_done      <= n_frame_done;
            end
        end
    end

    // A folded checksum only reaches bit 8 as exactly 256.
    assign sum_at_top   = r_running_sum[tlcc_pkg::W_SUM-1];
    assign sum_low_zero = (r_running_sum[tlcc_pkg::W_BYTE-1:0] == '0);
    assign length_ok    = (r_expected_length == '0) ||
                          (r_expected_length == tlcc_pkg::LEN_CODE0) ||
                          (r_expected_length == tlcc_pkg::LEN_CODE1) ||
                          (r_expected_length == tlcc_pkg::LEN_CODE2) ||
                          (r_expected_length == tlcc_pkg::LEN_CODE3);

    `TLCC_ASSERT_IMP(a_done_has_length, i_clk, i_rst_n, r_frame_done, r_expected_length != '0)
    `TLCC_ASSERT_IMP(a_sum_folded, i_clk, i_rst_n, sum_at_top, sum_low_zero)
    `TLCC_ASSERT_IMP(a_length_legal, i_clk, i_rst_n, 1'b1, length_ok)
    `TLCC_ASSERT_NXT(a_clear_after_last, i_clk, i_rst_n, i_fire && i_item.last, (r_byte_count == '0) && !r_frame_done)

endmodule

// ===== src/tlcc_out_reg.sv =====
// ----------------------------------------------------------------------------
// Telegram check output register
// Holds one verdict beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module tlcc_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tlcc_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output tlcc_pkg::t_result o_result
);

    logic              r_valid;
    logic              n_valid;
    tlcc_pkg::t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== bench/telegram_length_and_checksum_check_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Telegram length and checksum check testbench
// Streams received buffers through the block byte by byte. A model of the
// telegram rules inside the bench predicts the verdict for each buffer, and
// every verdict beat is compared with the oldest prediction. Directed buffers
// come first, then random buffers under several minimum-length settings, with
// random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module telegram_length_and_checksum_check_tb;

    // Idle spells on both streams are bounded, and each verdict follows its last byte
    // through the input and output registers, so a watchdog spell without a single beat
    // can only mean a hung block.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 6;

    typedef enum int {
        BUF_GOOD,
        BUF_BAD_SUM,
        BUF_TRAILING,
        BUF_TRUNCATED,
        BUF_NOISE
    } t_buffer_kind;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [4:0]  i_cfg_wdata = 5'd0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = 8'd0;   // [7:0] data_byte
    logic        i_s_tlast   = 1'b0;   // end_of_buffer
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [15:0] o_m_tdata;            // [1:0] status, [6:2] frame_length,
                                       // [14:7] computed_sum, [15] zero

    // Mirror of the block's per-buffer state and its one register.
    logic [tlcc_pkg::W_LEN-1:0] cfg_min_len = tlcc_pkg::MIN_LENGTH_RESET;
    logic [tlcc_pkg::W_LEN-1:0] tg_count    = '0;
    logic [tlcc_pkg::W_LEN-1:0] tg_len      = '0;
    logic [8:0]                 tg_sum      = '0;
    logic [7:0]                 tg_rx_sum   = '0;
    logic                       tg_done     = 1'b0;

    tlcc_pkg::t_result verdicts_due[$];
    tlcc_pkg::t_result verdict_seen;
    tlcc_pkg::t_result verdict_want;
    logic [7:0]        buf_q[$];

    int mismatches  = 0;
    int bytes_sent  = 0;
    int idle_cycles = 0;
    int rx_hold     = 0;
    bit steady_tx   = 1'b0;
    bit steady_rx   = 1'b0;

    telegram_length_and_checksum_check dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Telegram arithmetic
    // ------------------------------------------------------------------------

    // Bits 3:2 of the header byte pick one of four telegram lengths.
    function automatic logic [tlcc_pkg::W_LEN-1:0] frame_len_for(input logic [7:0] hdr);
        logic [tlcc_pkg::W_LEN-1:0] len;
        case (hdr[3:2])
            2'd0: len = tlcc_pkg::LEN_CODE0;
            2'd1: len = tlcc_pkg::LEN_CODE1;
            2'd2: len = tlcc_pkg::LEN_CODE2;
            default: len = tlcc_pkg::LEN_CODE3;
        endcase
        return len;
    endfunction

    // One checksum step, done in plain integers: add modulo 512, rotate the
    // nine bits left by two, and if the top bit comes out set, replace it by
    // an increment of the low eight bits (256 off, one on).
    function automatic logic [8:0] fold_in(input logic [8:0] acc, input logic [7:0] b);
        int s;
        int r;
        s = (int'(acc) + int'(b)) % 512;
        r = (s % 128) * 4 + s / 128;
        if (r > 255) begin
            r = r - 255;
        end
        return 9'(r);
    endfunction

    // Advances the mirror by one accepted byte and, on the last byte of a
    // buffer, records the verdict that the block owes for it.
    task automatic predict_byte(input logic [7:0] b, input logic last);
        tlcc_pkg::t_result v;
        if (!tg_done) begin
            if (tg_count == tlcc_pkg::IDX_LENGTH_BYTE) begin
                tg_len = frame_len_for(b);
            end
            if (tg_count == tlcc_pkg::IDX_SUM_BYTE) begin
                tg_rx_sum = b;
            end else begin
                tg_sum = fold_in(tg_sum, b);
            end
        end
        // The count sticks at its top value; beyond that only its
        // comparison with the minimum length still matters.
        if (tg_count != tlcc_pkg::COUNT_MAX) begin
            tg_count = tg_count + 1'b1;
        end
        if (tg_len != '0 && tg_count == tg_len) begin
            tg_done = 1'b1;
        end
        if (last) begin
            // A short buffer reports more bytes needed whatever else holds,
            // and so does a buffer that ends inside its telegram.
            if (tg_count < cfg_min_len || !tg_done) begin
                v.status = tlcc_pkg::ST_MORE;
            end else if (tg_sum[7:0] != tg_rx_sum) begin
                v.status = tlcc_pkg::ST_BAD_SUM;
            end else begin
                v.status = tlcc_pkg::ST_VALID;
            end
            v.frame_length = tg_len;
            v.computed_sum = tg_sum[7:0];
            verdicts_due.push_back(v);
            tg_count  = '0;
            tg_len    = '0;
            tg_sum    = '0;
            tg_rx_sum = '0;
            tg_done   = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stream drivers
    // ------------------------------------------------------------------------

    // Mostly short idle spells, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // Presents one byte beat and returns at the edge that accepts it. The
    // valid stays high on return, so a following beat may go out back to
    // back; whoever stops sending lowers it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = steady_tx ? 0 : idle_length();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        predict_byte(b, last);
        bytes_sent++;
    endtask

    // Sends the bytes held in buf_q as one buffer, tlast on the final one.
    task automatic send_buffer();
        for (int i = 0; i < buf_q.size(); i++) begin
            send_byte(buf_q[i], i == buf_q.size() - 1);
        end
        if ($urandom_range(0, 9) == 0) begin
            steady_tx = !steady_tx;
        end
    endtask

    // Stops sending and waits for every outstanding verdict, then lets the
    // pipeline settle so that nothing is still in flight.
    task automatic drain_verdicts();
        i_s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The register may only change while the block is idle.
    task automatic set_min_length(input logic [tlcc_pkg::W_LEN-1:0] value);
        drain_verdicts();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_min_len = value;
    endtask

    // ------------------------------------------------------------------------
    // Buffer builders
    // ------------------------------------------------------------------------

    // Writes the correct checksum into byte 2, taken over every other byte
    // of the telegram that byte 1 announces.
    task automatic seal_checksum();
        logic [8:0] acc;
        int         len;
        acc = '0;
        len = frame_len_for(buf_q[1]);
        for (int i = 0; i < len; i++) begin
            if (i != 2) begin
                acc = fold_in(acc, buf_q[i]);
            end
        end
        buf_q[2] = acc[7:0];
    endtask

    task automatic build_buffer(input t_buffer_kind kind);
        logic [7:0] hdr;
        int         len;
        int         keep;
        buf_q.delete();
        if (kind == BUF_NOISE) begin
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) begin
                buf_q.push_back(8'($urandom_range(0, 255)));
            end
        end else begin
            hdr = 8'($urandom_range(0, 255));
            len = frame_len_for(hdr);
            for (int i = 0; i < len; i++) begin
                buf_q.push_back(i == 1 ? hdr : 8'($urandom_range(0, 255)));
            end
            seal_checksum();
            case (kind)
                BUF_BAD_SUM: begin
                    buf_q[2] = buf_q[2] ^ 8'($urandom_range(1, 255));
                end
                BUF_TRAILING: begin
                    // Enough trailing bytes to run the count into saturation
                    // on the longer telegrams.
                    if ($urandom_range(0, 1) == 0) begin
                        buf_q[2] = buf_q[2] ^ 8'($urandom_range(1, 255));
                    end
                    repeat ($urandom_range(1, 25)) buf_q.push_back(8'($urandom_range(0, 255)));
                end
                BUF_TRUNCATED: begin
                    keep = $urandom_range(1, len - 1);
                    while (buf_q.size() > keep) void'(buf_q.pop_back());
                end
                default: begin
                end
            endcase
        end
    endtask

    // Well-formed telegrams with random content in the largest share, the rest damaged
    // telegrams and plain noise.
    task automatic random_buffers(input int n_bytes);
        int target;
        int r;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                build_buffer(BUF_GOOD);
            end else if (r < 60) begin
                build_buffer(BUF_BAD_SUM);
            end else if (r < 72) begin
                build_buffer(BUF_TRAILING);
            end else if (r < 84) begin
                build_buffer(BUF_TRUNCATED);
            end else begin
                build_buffer(BUF_NOISE);
            end
            send_buffer();
            if ($urandom_range(0, 24) == 0) begin
                drain_verdicts();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-made buffers under the reset value of the minimum length.
    task automatic test_directed_cases();
        // A single byte: too short, and no header seen, so length 0.
        buf_q = '{8'hFF};
        send_buffer();
        // The buffer ends three bytes into a 20-byte telegram.
        buf_q = '{8'h00, 8'h0C, 8'hFF};
        send_buffer();
        // A complete 6-byte telegram with the byte extremes in its body.
        buf_q = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h80};
        seal_checksum();
        send_buffer();
        // A 6-byte telegram with a spoilt checksum and two trailing bytes,
        // which must be counted but not summed.
        buf_q = '{8'h00, 8'hF3, 8'h00, 8'hFF, 8'h7F, 8'h01, 8'hAA, 8'h55};
        seal_checksum();
        buf_q[2] = buf_q[2] ^ 8'h01;
        send_buffer();
    endtask

    task automatic test_min_length_extremes();
        set_min_length(5'd2);
        random_buffers(160);
        set_min_length(5'd20);
        random_buffers(160);
    endtask

    // Below two the length check lets one- and two-byte buffers through,
    // but they still cannot hold a telegram.
    task automatic test_small_min_length();
        set_min_length(5'd0);
        random_buffers(60);
        set_min_length(5'd1);
        random_buffers(60);
    endtask

    // The sender holds off after each buffer until its verdict is in.
    task automatic test_pause_for_verdicts();
        set_min_length(5'($urandom_range(3, 19)));
        repeat (8) begin
            build_buffer(t_buffer_kind'($urandom_range(0, 4)));
            send_buffer();
            drain_verdicts();
        end
    endtask

    task automatic test_mixed_settings();
        repeat (3) begin
            set_min_length(5'($urandom_range(2, 20)));
            random_buffers(70);
        end
        set_min_length(tlcc_pkg::MIN_LENGTH_RESET);
        random_buffers(40);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_min_length_extremes();
        test_small_min_length();
        test_pause_for_verdicts();
        test_mixed_settings();
        drain_verdicts();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Verdict checking and receiver pacing
    // ------------------------------------------------------------------------

    // Every verdict beat is checked against the oldest prediction. The ready
    // is paced from the same edge: random stalls, with spells of none.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            verdict_seen = tlcc_pkg::t_result'(o_m_tdata[14:0]);
            if (verdicts_due.size() == 0) begin
                $error("verdict beat %h arrived with no buffer outstanding", o_m_tdata);
                mismatches++;
            end else begin
                verdict_want = verdicts_due.pop_front();
                if (verdict_seen.status != verdict_want.status) begin
                    $error("status: expected %0d, got %0d",
                           verdict_want.status, verdict_seen.status);
                    mismatches++;
                end
                if (verdict_seen.frame_length != verdict_want.frame_length) begin
                    $error("frame_length: expected %0d, got %0d",
                           verdict_want.frame_length, verdict_seen.frame_length);
                    mismatches++;
                end
                if (verdict_seen.computed_sum != verdict_want.computed_sum) begin
                    $error("computed_sum: expected %0d, got %0d",
                           verdict_want.computed_sum, verdict_seen.computed_sum);
                    mismatches++;
                end
                if (o_m_tdata[15] !== 1'b0) begin
                    $error("tdata padding: expected 0, got %b", o_m_tdata[15]);
                    mismatches++;
                end
            end
        end
        if (rx_hold != 0) begin
            i_m_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (!steady_rx && $urandom_range(0, 3) == 0) begin
            i_m_tready <= 1'b0;
            rx_hold <= idle_length();
        end else begin
            i_m_tready <= 1'b1;
        end
        if ($urandom_range(0, 99) == 0) begin
            steady_rx <= !steady_rx;
        end
    end

    // Ends the run if neither stream moves a beat for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// ===== files.f =====
+incdir+src
src/tlcc_pkg.sv
src/tlcc_in_reg.sv
src/tlcc_core.sv
src/tlcc_out_reg.sv
src/telegram_length_and_checksum_check.sv
bench/telegram_length_and_checksum_check_tb.sv
